[src/sensor_moving_average_baseline_core_macros.svh]
// Assertion macros shared by the moving-average baseline RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SENSOR_MOVING_AVERAGE_BASELINE_CORE_MACROS_SVH
`define SENSOR_MOVING_AVERAGE_BASELINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMAB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/smab_pkg.sv]
// Shared types and constants for the moving-average baseline block.
// No dependencies; compile first.
package smab_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int DEV_W    = 13;
    localparam int CNT_W    = 20;
    localparam int DIV_N_W  = 32;
    localparam int DIV_D_W  = 20;
    localparam int DIV_C_W  = 5;

    localparam logic [TIME_W-1:0] SETTLE_MS  = 32'd1000;
    localparam logic [TIME_W-1:0] WIN_MS_RST = 32'd10000;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = 20'hFFFFF;

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [TIME_W-1:0]   time_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smab_div_stat_t;

endpackage

[src/smab_if.sv]
// Handshake channel interfaces: request, result and configuration write.
// Depends on smab_pkg.
interface smab_req_if import smab_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    req_type;
    sample_t sample_value;
    time_t   time_ms;

    modport source (output valid, output req_type, output sample_value, output time_ms,
                    input ready);
    modport sink   (input valid, input req_type, input sample_value, input time_ms,
                    output ready);
endinterface

interface smab_rsp_if import smab_pkg::*; ();
    logic                    valid;
    logic                    ready;
    sample_t                 mean_value;
    logic signed [DEV_W-1:0] deviation;
    logic                    baseline_valid;

    modport source (output valid, output mean_value, output deviation,
                    output baseline_valid, input ready);
    modport sink   (input valid, input mean_value, input deviation,
                    input baseline_valid, output ready);
endinterface

interface smab_cfg_if import smab_pkg::*; ();
    logic  valid;
    logic  ready;
    time_t baseline_window_ms;

    modport source (output valid, output baseline_window_ms, input ready);
    modport sink   (input valid, input baseline_window_ms, output ready);
endinterface

[src/sensor_moving_average_baseline_core.sv]
// Sliding-window mean with one-time baseline calibration (top level).
// Depends on smab_pkg, smab_if, smab_ram, smab_div and the assertion macros.
//
// Usage:
//   req  - one beat per item: req_type 0 is a start event (clears the window and
//          the baseline, records time_ms as start time), 1 is a timestamped sample.
//   rsp  - exactly one beat per request: mean_value, deviation, baseline_valid.
//          A start event answers with all fields zero.
//   cfg  - single-register write channel (baseline_window_ms); always ready.
//          Write it only while the block is idle.
// Throughput: one item at a time. A sample passes a RAM read step, the serial
// division for the mean, a baseline update step and an output load; the next request
// is taken once the result has been loaded. The sample that fixes the baseline adds
// a second serial division. A start event goes straight to the output load.
// Reset: all window, sum and baseline state clears, the window register returns
// to 10000 ms. The ring needs no clearing pass: entries past the fill count read
// as zero.
// Stall: the result sits in an output register; the next request is taken while
// it waits, and the block only holds in its final state if a second result is
// ready before the first has been taken.
`include "sensor_moving_average_baseline_core_macros.svh"

module sensor_moving_average_baseline_core import smab_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    smab_req_if.sink      req,
    smab_rsp_if.source    rsp,
    smab_cfg_if.sink      cfg
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + FILL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_MDIV   = 3'd2;
    localparam logic [2:0] ST_BASE   = 3'd3;
    localparam logic [2:0] ST_BDIV   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Control and calibration state.
    logic [2:0]        state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    time_t             start_reg, start_next;
    logic [DIV_N_W-1:0] bsum_reg, bsum_next;
    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    sample_t           level_reg, level_next;
    logic              bdone_reg, bdone_next;
    time_t             win_reg, win_next;
    logic              out_valid_reg, out_valid_next;

    // Per-item working registers.
    sample_t           sample_reg, sample_next;
    time_t             time_reg, time_next;
    sample_t           mean_reg, mean_next;

    // Output payload.
    sample_t                 out_mean_reg, out_mean_next;
    logic signed [DEV_W-1:0] out_dev_reg, out_dev_next;
    logic                    out_bv_reg, out_bv_next;

    logic              req_fire;
    logic              out_load;
    sample_t           ring_rd;
    sample_t           ring_old;
    logic              ring_full;
    time_t             elapsed;
    logic [DIV_N_W-1:0] bsum_add;
    logic [CNT_W-1:0]  bcnt_add;
    logic              count_ok;
    logic              fix_now;

    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_N_W-1:0] div_quot;
    smab_div_stat_t     div_stat;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // Entries not yet written since the last clear read as zero.
    assign ring_full = (fill_reg == FILL_W'(WINDOW));
    assign ring_old  = ring_full ? ring_rd : '0;

    // Baseline accumulation: elapsed time wraps mod 2^32.
    assign elapsed  = time_reg - start_reg;
    assign count_ok = (elapsed > SETTLE_MS) && (bcnt_reg != COUNT_MAX);
    assign bsum_add = count_ok ? bsum_reg + {{(DIV_N_W - SAMPLE_W){1'b0}}, mean_reg} : bsum_reg;
    assign bcnt_add = count_ok ? bcnt_reg + 1'b1 : bcnt_reg;
    assign fix_now  = !bdone_reg && (elapsed >= win_reg) && (bcnt_add != '0);

    smab_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (req_fire),
        .rd_addr (wp_reg),
        .rd_data (ring_rd)
    );

    smab_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        start_next     = start_reg;
        bsum_next      = bsum_reg;
        bcnt_next      = bcnt_reg;
        level_next     = level_reg;
        bdone_next     = bdone_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        time_next      = time_reg;
        mean_next      = mean_reg;
        out_mean_next  = out_mean_reg;
        out_dev_next   = out_dev_reg;
        out_bv_next    = out_bv_reg;
        div_start      = 1'b0;
        div_num        = {{(DIV_N_W - SUM_W){1'b0}}, sum_reg};
        div_den        = {{(DIV_D_W - FILL_W){1'b0}}, fill_reg};

        if (cfg.valid && cfg.ready)
        begin
            win_next = cfg.baseline_window_ms;
        end

        // Drop the held result once the receiver takes it.
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    sample_next = req.sample_value;
                    time_next   = req.time_ms;
                    if (req.req_type == REQ_START)
                    begin
                        wp_next    = '0;
                        fill_next  = '0;
                        sum_next   = '0;
                        bsum_next  = '0;
                        bcnt_next  = '0;
                        level_next = '0;
                        bdone_next = 1'b0;
                        start_next = req.time_ms;
                        mean_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Retire the oldest entry, write the new one and start the mean.
                sum_next  = sum_reg - {{FILL_W{1'b0}}, ring_old}
                            + {{FILL_W{1'b0}}, sample_reg};
                fill_next = ring_full ? fill_reg : fill_reg + 1'b1;
                wp_next   = (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                div_start = 1'b1;
                div_num   = {{(DIV_N_W - SUM_W){1'b0}}, sum_next};
                div_den   = {{(DIV_D_W - FILL_W){1'b0}}, fill_next};
                state_next = ST_MDIV;
            end
            ST_MDIV:
            begin
                if (div_stat.done)
                begin
                    mean_next  = div_quot[SAMPLE_W-1:0];
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (!bdone_reg)
                begin
                    bsum_next = bsum_add;
                    bcnt_next = bcnt_add;
                end
                if (fix_now)
                begin
                    div_start  = 1'b1;
                    div_num    = bsum_add;
                    div_den    = bcnt_add;
                    state_next = ST_BDIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BDIV:
            begin
                if (div_stat.done)
                begin
                    level_next = div_quot[SAMPLE_W-1:0];
                    bdone_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold here only while an earlier result still waits.
                if (out_load)
                begin
                    out_mean_next  = mean_reg;
                    out_dev_next   = bdone_reg
                                     ? $signed({1'b0, mean_reg}) - $signed({1'b0, level_reg})
                                     : '0;
                    out_bv_next    = bdone_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            start_reg     <= '0;
            bsum_reg      <= '0;
            bcnt_reg      <= '0;
            level_reg     <= '0;
            bdone_reg     <= 1'b0;
            win_reg       <= WIN_MS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            start_reg     <= start_next;
            bsum_reg      <= bsum_next;
            bcnt_reg      <= bcnt_next;
            level_reg     <= level_next;
            bdone_reg     <= bdone_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        time_reg     <= time_next;
        mean_reg     <= mean_next;
        out_mean_reg <= out_mean_next;
        out_dev_reg  <= out_dev_next;
        out_bv_reg   <= out_bv_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.mean_value     = out_mean_reg;
    assign rsp.deviation      = out_dev_reg;
    assign rsp.baseline_valid = out_bv_reg;

    `SMAB_ASSERT_SAME(a_fill_range, clk, rst_n, 1'b1, fill_reg <= FILL_W'(WINDOW),
                      "fill count beyond window")
    `SMAB_ASSERT_SAME(a_done_counted, clk, rst_n, bdone_reg, bcnt_reg != '0,
                      "baseline fixed with no means counted")
    `SMAB_ASSERT_SAME(a_div_free, clk, rst_n, div_start, !div_stat.busy,
                      "divider started while busy")
    `SMAB_ASSERT_NEXT(a_result_loaded, clk, rst_n, out_load, rsp.valid,
                      "result not presented after load")
    `SMAB_ASSERT_SAME(a_wait_div, clk, rst_n, div_stat.busy,
                      state_reg == ST_MDIV || state_reg == ST_BDIV,
                      "divider busy outside a division state")

endmodule

[src/smab_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smab_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/smab_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on smab_pkg.
module smab_div import smab_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output smab_div_stat_t     stat
);

    logic [DIV_N_W-1:0] num_reg, num_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_C_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign shifted = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_N_W-2:0], ge};
            rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_C_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
